FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is asserted
`define TVUP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tvup assertion failed");

// concurrent assertion that also holds across reset
`define TVUP_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tvup assertion failed");

`endif

FILE: design/tvup_pkg.sv
// ----------------------------------------------------------------------------
// tvup_pkg
// codes for request types, devices, levels and configuration registers
// ----------------------------------------------------------------------------
package tvup_pkg;

    typedef logic [2:0] t_req_type;
    typedef logic [1:0] t_dev;
    typedef logic [1:0] t_level;
    typedef logic [1:0] t_cfg_index;

    localparam t_req_type REQ_ADD_EXT  = 3'd0;
    localparam t_req_type REQ_SUB_EXT  = 3'd1;
    localparam t_req_type REQ_ADD_FILE = 3'd2;
    localparam t_req_type REQ_SUB_FILE = 3'd3;
    localparam t_req_type REQ_SELECT   = 3'd4;

    // device codes, the size row sits at the fourth code
    localparam t_dev DEV_WAL  = 2'd0;
    localparam t_dev DEV_DB   = 2'd1;
    localparam t_dev DEV_SLOW = 2'd2;
    localparam t_dev DEV_SIZE = 2'd3;

    localparam t_level LVL_LOG  = 2'd0;
    localparam t_level LVL_WAL  = 2'd1;
    localparam t_level LVL_DB   = 2'd2;
    localparam t_level LVL_SLOW = 2'd3;

    localparam t_cfg_index CFG_WAL_CAP   = 2'd0;
    localparam t_cfg_index CFG_DB_CAP    = 2'd1;
    localparam t_cfg_index CFG_SLOW_CAP  = 2'd2;
    localparam t_cfg_index CFG_ROOM_SLOW = 2'd3;

endpackage

FILE: design/tiered_volume_usage_placement_top.sv
// ----------------------------------------------------------------------------
// tiered volume usage placement tracker
// an accepted request moves through the stage one, stage two and output registers
// throughput: one request per cycle while no result stalls, table updates land at the end of stage one
// stage two works out placement and free space from registered snapshots
// reset clears usage, peak and file tables, capacities and all valid flags
// ----------------------------------------------------------------------------
module tiered_volume_usage_placement_top
    import tvup_pkg::*;
#(
    parameter int BYTE_COUNT_BITS = 64,
    parameter int FILE_COUNT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  t_cfg_index                 i_cfg_index,
    input  logic [BYTE_COUNT_BITS-1:0] i_cfg_data,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  t_req_type                  i_req_type,
    input  logic                       i_hint_valid,
    input  t_level                     i_level,
    input  t_dev                       i_device,
    input  logic [BYTE_COUNT_BITS-1:0] i_amount,
    input  logic                       i_count_file,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output t_dev                       o_preferred_device,
    output logic [BYTE_COUNT_BITS-1:0] o_device_space_left,
    output logic [BYTE_COUNT_BITS-1:0] o_level_bytes_used,
    output logic [BYTE_COUNT_BITS-1:0] o_level_bytes_peak,
    output logic [FILE_COUNT_BITS-1:0] o_level_file_total
);

    typedef logic [BYTE_COUNT_BITS-1:0] t_bytes;
    typedef logic [FILE_COUNT_BITS-1:0] t_files;

    t_bytes    r_cap_wal, r_cap_db, r_cap_slow, r_room_slow;
    logic      advance;

    logic      r_a_valid;
    t_req_type r_a_req;
    logic      r_a_hint;
    t_level    r_a_level;
    t_dev      r_a_device;
    t_bytes    r_a_amount;
    logic      r_a_count;

    t_bytes    r_usage [4][4];
    t_bytes    n_usage [4][4];
    t_bytes    r_peak  [4][4];
    t_bytes    n_peak  [4][4];
    t_bytes    r_total [3];
    t_bytes    n_total [3];
    t_files    r_files [4];
    t_files    n_files [4];
    t_bytes    r_busy, n_busy;

    logic      do_ext, do_file, do_add, do_sub, raise, busy_cell;
    t_dev      wr_row;
    t_bytes    cell_old, cell_new, peak_old, dev_total;

    logic      r_b_valid;
    t_level    r_b_level;
    t_dev      r_b_device;
    t_bytes    r_b_used, r_b_peak, r_b_total, r_b_busy, r_b_slow_used;
    t_files    r_b_files;

    t_bytes    db_left, db_room, dev_cap;
    t_dev      n_pref;
    t_bytes    n_space;

    logic      r_o_valid;
    t_dev      r_o_pref;
    t_bytes    r_o_space, r_o_used, r_o_peak;
    t_files    r_o_files;

    assign advance     = !r_o_valid || i_rsp_ready;
    assign o_req_ready = advance;

    // stage one: table update
    always_comb begin
        do_ext  = r_a_hint && (r_a_device != DEV_SIZE) &&
                  ((r_a_req == REQ_ADD_EXT) || (r_a_req == REQ_SUB_EXT));
        do_file = r_a_hint && ((r_a_req == REQ_ADD_FILE) || (r_a_req == REQ_SUB_FILE));
        do_add  = r_a_hint && (((r_a_req == REQ_ADD_EXT) && (r_a_device != DEV_SIZE)) ||
                               (r_a_req == REQ_ADD_FILE));
        do_sub  = r_a_hint && (((r_a_req == REQ_SUB_EXT) && (r_a_device != DEV_SIZE)) ||
                               (r_a_req == REQ_SUB_FILE));
        wr_row  = do_file ? DEV_SIZE : r_a_device;

        cell_old  = r_usage[wr_row][r_a_level];
        cell_new  = do_add ? cell_old + r_a_amount : cell_old - r_a_amount;
        peak_old  = r_peak[wr_row][r_a_level];
        raise     = do_add && (cell_new > peak_old);
        busy_cell = ((wr_row == DEV_DB) && (r_a_level != LVL_SLOW)) ||
                    ((wr_row == DEV_SLOW) && (r_a_level == LVL_DB));

        n_usage = r_usage;
        n_peak  = r_peak;
        n_total = r_total;
        n_files = r_files;
        n_busy  = r_busy;

        if (do_add || do_sub) begin
            n_usage[wr_row][r_a_level] = cell_new;
        end
        if (raise) begin
            n_peak[wr_row][r_a_level] = cell_new;
            if (busy_cell) begin
                n_busy = r_busy + cell_new - peak_old;
            end
        end
        if (do_ext) begin
            n_total[r_a_device] = do_add ? r_total[r_a_device] + r_a_amount
                                         : r_total[r_a_device] - r_a_amount;
        end
        if (do_file && r_a_count) begin
            n_files[r_a_level] = do_add ? r_files[r_a_level] + t_files'(1)
                                        : r_files[r_a_level] - t_files'(1);
        end

        if (r_a_device == DEV_SIZE) begin
            dev_total = '0;
        end else begin
            dev_total = n_total[r_a_device];
        end
    end

    // stage two: placement and free space
    always_comb begin
        db_left = (r_cap_db > r_b_busy) ? r_cap_db - r_b_busy : '0;
        db_room = (r_room_slow < db_left) ? r_room_slow : db_left;

        case (r_b_level)
            LVL_LOG:  n_pref = DEV_WAL;
            LVL_WAL:  n_pref = DEV_WAL;
            LVL_DB:   n_pref = DEV_DB;
            default:  n_pref = ((r_room_slow != '0) && (db_room > r_b_slow_used))
                               ? DEV_DB : DEV_SLOW;
        endcase

        case (r_b_device)
            DEV_WAL:  dev_cap = r_cap_wal;
            DEV_DB:   dev_cap = r_cap_db;
            DEV_SLOW: dev_cap = r_cap_slow;
            default:  dev_cap = '0;
        endcase

        n_space = (dev_cap > r_b_total) ? dev_cap - r_b_total : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_wal   <= '0;
            r_cap_db    <= '0;
            r_cap_slow  <= '0;
            r_room_slow <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAL_CAP:   r_cap_wal   <= i_cfg_data;
                CFG_DB_CAP:    r_cap_db    <= i_cfg_data;
                CFG_SLOW_CAP:  r_cap_slow  <= i_cfg_data;
                CFG_ROOM_SLOW: r_room_slow <= i_cfg_data;
                default:       r_room_slow <= r_room_slow;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_req_valid;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_usage[r][c] <= '0;
                    r_peak[r][c]  <= '0;
                end
                r_files[r] <= '0;
            end
            for (int d = 0; d < 3; d++) begin
                r_total[d] <= '0;
            end
            r_busy <= '0;
        end else if (advance && r_a_valid) begin
            r_usage <= n_usage;
            r_peak  <= n_peak;
            r_total <= n_total;
            r_files <= n_files;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (i_req_valid) begin
                r_a_req    <= i_req_type;
                r_a_hint   <= i_hint_valid;
                r_a_level  <= i_level;
                r_a_device <= i_device;
                r_a_amount <= i_amount;
                r_a_count  <= i_count_file;
            end
            if (r_a_valid) begin
                r_b_level     <= r_a_level;
                r_b_device    <= r_a_device;
                r_b_used      <= n_usage[r_a_device][r_a_level];
                r_b_peak      <= n_peak[r_a_device][r_a_level];
                r_b_files     <= n_files[r_a_level];
                r_b_total     <= dev_total;
                r_b_busy      <= n_busy;
                r_b_slow_used <= n_usage[DEV_DB][LVL_SLOW];
            end
            if (r_b_valid) begin
                r_o_pref  <= n_pref;
                r_o_space <= n_space;
                r_o_used  <= r_b_used;
                r_o_peak  <= r_b_peak;
                r_o_files <= r_b_files;
            end
        end
    end

    assign o_rsp_valid         = r_o_valid;
    assign o_preferred_device  = r_o_pref;
    assign o_device_space_left = r_o_space;
    assign o_level_bytes_used  = r_o_used;
    assign o_level_bytes_peak  = r_o_peak;
    assign o_level_file_total  = r_o_files;

endmodule

FILE: design/tvup_checker.sv
// ----------------------------------------------------------------------------
// tvup_checker
// port level checks for the usage placement tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvup_checker
    import tvup_pkg::*;
#(
    parameter int BYTE_COUNT_BITS = 64,
    parameter int FILE_COUNT_BITS = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_req_ready,
    input logic                       o_rsp_valid,
    input logic                       i_rsp_ready,
    input t_dev                       o_preferred_device,
    input logic [BYTE_COUNT_BITS-1:0] o_device_space_left,
    input logic [BYTE_COUNT_BITS-1:0] o_level_bytes_used,
    input logic [FILE_COUNT_BITS-1:0] o_level_file_total
);

    property p_rsp_hold;
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_device_space_left) &&
            $stable(o_level_bytes_used) && $stable(o_level_file_total);
    endproperty

    // stalled result stays valid and keeps its space, usage and file count fields
    `TVUP_ASSERT(a_rsp_hold, i_clk, i_rst_n, p_rsp_hold)

    // an empty result register never blocks new requests
    `TVUP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_rsp_valid |-> o_req_ready)

    // placement never points at the size row
    `TVUP_ASSERT(a_pref_legal, i_clk, i_rst_n, o_rsp_valid |-> o_preferred_device != DEV_SIZE)

    // reset leaves no stale result
    `TVUP_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !o_rsp_valid)

endmodule

bind tiered_volume_usage_placement_top tvup_checker #(
    .BYTE_COUNT_BITS(BYTE_COUNT_BITS),
    .FILE_COUNT_BITS(FILE_COUNT_BITS)
) u_tvup_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_req_ready         (o_req_ready),
    .o_rsp_valid         (o_rsp_valid),
    .i_rsp_ready         (i_rsp_ready),
    .o_preferred_device  (o_preferred_device),
    .o_device_space_left (o_device_space_left),
    .o_level_bytes_used  (o_level_bytes_used),
    .o_level_file_total  (o_level_file_total)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: tiered volume usage placement tracker
// directed table of requests and register writes, then random phases under
// several capacity settings; every response is checked field by field against
// a scoreboard fed by fixed rows or an in-bench model of usage, peak and file tables
// ----------------------------------------------------------------------------
module tb_top;
    import tvup_pkg::*;

    localparam int BYTES_W       = 64;
    localparam int FILES_W       = 32;
    localparam int TOTAL_COL     = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_REQS    = 200;
    localparam int NUM_PHASES    = 5;
    localparam int CALM_PHASE    = 2;

    localparam t_req_type REQ_SPARE_LO = 3'd5;
    localparam t_req_type REQ_SPARE_HI = 3'd7;

    typedef logic [BYTES_W-1:0] t_bytes;
    typedef logic [FILES_W-1:0] t_files;

    localparam t_bytes B_MAX = {BYTES_W{1'b1}};
    localparam t_bytes B_TOP = {1'b1, {(BYTES_W-1){1'b0}}};

    typedef struct packed {
        t_dev   pref;
        t_bytes space;
        t_bytes used;
        t_bytes peak;
        t_files files;
    } rsp_t;

    typedef struct packed {
        t_req_type req;
        logic      hint;
        t_level    lvl;
        t_dev      dev;
        t_bytes    amt;
        logic      cnt;
        logic      fixed;
        rsp_t      want;
    } req_item_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        t_cfg_index cfg;
        req_item_t  item;
    } stim_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_bytes     i_cfg_data;
    logic       i_req_valid;
    logic       o_req_ready;
    t_req_type  i_req_type;
    logic       i_hint_valid;
    t_level     i_level;
    t_dev       i_device;
    t_bytes     i_amount;
    logic       i_count_file;
    logic       o_rsp_valid;
    logic       i_rsp_ready;
    t_dev       o_preferred_device;
    t_bytes     o_device_space_left;
    t_bytes     o_level_bytes_used;
    t_bytes     o_level_bytes_peak;
    t_files     o_level_file_total;

    tiered_volume_usage_placement_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_req_valid         (i_req_valid),
        .o_req_ready         (o_req_ready),
        .i_req_type          (i_req_type),
        .i_hint_valid        (i_hint_valid),
        .i_level             (i_level),
        .i_device            (i_device),
        .i_amount            (i_amount),
        .i_count_file        (i_count_file),
        .o_rsp_valid         (o_rsp_valid),
        .i_rsp_ready         (i_rsp_ready),
        .o_preferred_device  (o_preferred_device),
        .o_device_space_left (o_device_space_left),
        .o_level_bytes_used  (o_level_bytes_used),
        .o_level_bytes_peak  (o_level_bytes_peak),
        .o_level_file_total  (o_level_file_total)
    );

    // model state
    t_bytes usage_tbl [4][5];
    t_bytes peak_tbl  [4][5];
    t_files file_tbl  [5];
    t_bytes wal_cap, db_cap, slow_cap, slow_room;

    rsp_t      placement_expect_q [$];
    req_item_t req_backlog [$];
    stim_row_t dir_tbl [$];
    int        fail_count;
    int        cycle_count;
    bit        calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_bytes wide_rand();
        return {$urandom, $urandom};
    endfunction

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 35);
    endfunction

    function automatic void bump_usage(int row, int col, t_bytes amt);
        usage_tbl[row][col] = usage_tbl[row][col] + amt;
        if (usage_tbl[row][col] > peak_tbl[row][col]) begin
            peak_tbl[row][col] = usage_tbl[row][col];
        end
    endfunction

    function automatic void drop_usage(int row, int col, t_bytes amt);
        usage_tbl[row][col] = usage_tbl[row][col] - amt;
    endfunction

    function automatic rsp_t account_and_place(req_item_t it);
        rsp_t   r;
        t_bytes busy, left, room, cap;
        int     d, l;
        d = int'(it.dev);
        l = int'(it.lvl);
        if (it.hint) begin
            case (it.req)
                REQ_ADD_EXT: if (it.dev != DEV_SIZE) begin
                    bump_usage(d, l, it.amt);
                    bump_usage(d, TOTAL_COL, it.amt);
                end
                REQ_SUB_EXT: if (it.dev != DEV_SIZE) begin
                    drop_usage(d, l, it.amt);
                    drop_usage(d, TOTAL_COL, it.amt);
                end
                REQ_ADD_FILE: begin
                    bump_usage(int'(DEV_SIZE), l, it.amt);
                    if (it.cnt) begin
                        file_tbl[l] = file_tbl[l] + t_files'(1);
                        file_tbl[TOTAL_COL] = file_tbl[TOTAL_COL] + t_files'(1);
                    end
                end
                REQ_SUB_FILE: begin
                    drop_usage(int'(DEV_SIZE), l, it.amt);
                    if (it.cnt) begin
                        file_tbl[l] = file_tbl[l] - t_files'(1);
                        file_tbl[TOTAL_COL] = file_tbl[TOTAL_COL] - t_files'(1);
                    end
                end
                default: ;
            endcase
        end

        if (it.lvl == LVL_LOG || it.lvl == LVL_WAL) begin
            r.pref = DEV_WAL;
        end else if (it.lvl == LVL_DB) begin
            r.pref = DEV_DB;
        end else begin
            r.pref = DEV_SLOW;
            if (slow_room != '0) begin
                busy = peak_tbl[DEV_DB][LVL_LOG] + peak_tbl[DEV_DB][LVL_WAL]
                     + peak_tbl[DEV_DB][LVL_DB] + peak_tbl[DEV_SLOW][LVL_DB];
                left = (db_cap > busy) ? db_cap - busy : '0;
                room = (slow_room < left) ? slow_room : left;
                if (room > usage_tbl[DEV_DB][LVL_SLOW]) begin
                    r.pref = DEV_DB;
                end
            end
        end

        case (it.dev)
            DEV_WAL:  cap = wal_cap;
            DEV_DB:   cap = db_cap;
            DEV_SLOW: cap = slow_cap;
            default:  cap = '0;
        endcase
        // the size row has no capacity, so it never reports free space
        r.space = (it.dev != DEV_SIZE && cap > usage_tbl[d][TOTAL_COL])
                ? cap - usage_tbl[d][TOTAL_COL] : '0;
        r.used  = usage_tbl[d][l];
        r.peak  = peak_tbl[d][l];
        r.files = file_tbl[l];
        return r;
    endfunction

    function automatic stim_row_t req_row(t_req_type req, logic hint, t_level lvl, t_dev dev,
                                          t_bytes amt, logic cnt, logic fixed, rsp_t want);
        stim_row_t s;
        s = '0;
        s.kind = ROW_REQ;
        s.item = '{req, hint, lvl, dev, amt, cnt, fixed, want};
        return s;
    endfunction

    function automatic stim_row_t cfg_row(t_cfg_index idx, t_bytes val);
        stim_row_t s;
        s = '0;
        s.kind     = ROW_CFG;
        s.cfg      = idx;
        s.item.amt = val;
        return s;
    endfunction

    function automatic req_item_t random_req();
        req_item_t it;
        int        pick;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.req = REQ_ADD_EXT;
        else if (pick < 50) it.req = REQ_SUB_EXT;
        else if (pick < 65) it.req = REQ_ADD_FILE;
        else if (pick < 77) it.req = REQ_SUB_FILE;
        else if (pick < 92) it.req = REQ_SELECT;
        else                it.req = t_req_type'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        it.hint = ($urandom_range(0, 9) != 0);
        it.lvl  = t_level'($urandom_range(0, 3));
        it.dev  = ($urandom_range(0, 9) == 0) ? DEV_SIZE : t_dev'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 65)      it.amt = t_bytes'($urandom_range(0, 300));
        else if (pick < 85) it.amt = t_bytes'($urandom_range(0, 1 << 20));
        else if (pick < 95) it.amt = wide_rand();
        else if (pick < 98) it.amt = B_MAX;
        else                it.amt = B_TOP;
        it.cnt = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic check_field(string name, t_bytes want, t_bytes got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(t_cfg_index idx, t_bytes val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_WAL_CAP:  wal_cap   = val;
            CFG_DB_CAP:   db_cap    = val;
            CFG_SLOW_CAP: slow_cap  = val;
            default:      slow_room = val;
        endcase
    endtask

    task automatic settle();
        while (placement_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_requests();
        req_item_t cur;
        rsp_t      pred;
        bit        busy;
        busy = 1'b0;
        cur  = '0;
        while (busy || req_backlog.size() != 0) begin
            @(posedge i_clk);
            if (busy && o_req_ready) begin
                pred = account_and_place(cur);
                placement_expect_q.push_back(cur.fixed ? cur.want : pred);
                busy = 1'b0;
            end
            if (!busy) begin
                if (req_backlog.size() != 0 && !idle_roll()) begin
                    cur = req_backlog.pop_front();
                    i_req_type   <= cur.req;
                    i_hint_valid <= cur.hint;
                    i_level      <= cur.lvl;
                    i_device     <= cur.dev;
                    i_amount     <= cur.amt;
                    i_count_file <= cur.cnt;
                    i_req_valid  <= 1'b1;
                    busy = 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    endtask

    // response side
    always @(posedge i_clk) begin
        i_rsp_ready <= !idle_roll();
    end

    always @(posedge i_clk) begin
        rsp_t want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (placement_expect_q.size() == 0) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                want = placement_expect_q.pop_front();
                check_field("preferred_device", t_bytes'(want.pref),
                            t_bytes'(o_preferred_device));
                check_field("device_space_left", want.space, o_device_space_left);
                check_field("level_bytes_used", want.used, o_level_bytes_used);
                check_field("level_bytes_peak", want.peak, o_level_bytes_peak);
                check_field("level_file_total", t_bytes'(want.files),
                            t_bytes'(o_level_file_total));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tiered_volume_usage_placement_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_bytes cfg_val [4];
        calm        = 1'b0;
        wal_cap     = '0;
        db_cap      = '0;
        slow_cap    = '0;
        slow_room   = '0;
        foreach (usage_tbl[r, c]) begin
            usage_tbl[r][c] = '0;
            peak_tbl[r][c]  = '0;
        end
        foreach (file_tbl[c]) file_tbl[c] = '0;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_WAL_CAP;
        i_cfg_data   <= '0;
        i_req_valid  <= 1'b0;
        i_req_type   <= REQ_SELECT;
        i_hint_valid <= 1'b0;
        i_level      <= LVL_LOG;
        i_device     <= DEV_WAL;
        i_amount     <= '0;
        i_count_file <= 1'b0;
        i_rsp_ready  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_tbl = '{
            req_row(REQ_SELECT, 1'b1, LVL_LOG, DEV_WAL, 64'd0, 1'b0, 1'b1,
                    '{DEV_WAL, 64'd0, 64'd0, 64'd0, 32'd0}),
            req_row(REQ_SELECT, 1'b1, LVL_SLOW, DEV_DB, 64'd0, 1'b0, 1'b1,
                    '{DEV_SLOW, 64'd0, 64'd0, 64'd0, 32'd0}),
            req_row(REQ_SELECT, 1'b1, LVL_DB, DEV_SLOW, 64'd0, 1'b0, 1'b1,
                    '{DEV_DB, 64'd0, 64'd0, 64'd0, 32'd0}),
            req_row(REQ_ADD_EXT, 1'b1, LVL_WAL, DEV_WAL, B_MAX, 1'b0, 1'b1,
                    '{DEV_WAL, 64'd0, B_MAX, B_MAX, 32'd0}),
            // usage wraps to zero, peak holds
            req_row(REQ_ADD_EXT, 1'b1, LVL_WAL, DEV_WAL, 64'd1, 1'b0, 1'b1,
                    '{DEV_WAL, 64'd0, 64'd0, B_MAX, 32'd0}),
            req_row(REQ_SUB_EXT, 1'b1, LVL_WAL, DEV_WAL, 64'd1, 1'b0, 1'b0, '0),
            req_row(REQ_ADD_FILE, 1'b1, LVL_DB, DEV_SIZE, 64'd5, 1'b1, 1'b1,
                    '{DEV_DB, 64'd0, 64'd5, 64'd5, 32'd1}),
            req_row(REQ_SUB_FILE, 1'b1, LVL_DB, DEV_SIZE, 64'd5, 1'b1, 1'b1,
                    '{DEV_DB, 64'd0, 64'd0, 64'd5, 32'd0}),
            // file count wraps below zero
            req_row(REQ_SUB_FILE, 1'b1, LVL_LOG, DEV_WAL, 64'd0, 1'b1, 1'b1,
                    '{DEV_WAL, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF}),
            req_row(REQ_ADD_FILE, 1'b1, LVL_LOG, DEV_SIZE, B_TOP, 1'b0, 1'b0, '0),
            // null hint changes nothing
            req_row(REQ_ADD_EXT, 1'b0, LVL_SLOW, DEV_SLOW, 64'd100, 1'b1, 1'b1,
                    '{DEV_SLOW, 64'd0, 64'd0, 64'd0, 32'd0}),
            req_row(REQ_SPARE_LO, 1'b1, LVL_DB, DEV_DB, 64'd7, 1'b1, 1'b0, '0),
            req_row(REQ_SPARE_HI, 1'b1, LVL_WAL, DEV_DB, 64'd9, 1'b1, 1'b0, '0),
            // extent on the size row is dropped
            req_row(REQ_ADD_EXT, 1'b1, LVL_SLOW, DEV_SIZE, 64'd44, 1'b0, 1'b0, '0),
            cfg_row(CFG_WAL_CAP, B_MAX),
            cfg_row(CFG_DB_CAP, 64'd1000),
            cfg_row(CFG_SLOW_CAP, 64'd0),
            cfg_row(CFG_ROOM_SLOW, 64'd300),
            req_row(REQ_SELECT, 1'b1, LVL_SLOW, DEV_DB, 64'd0, 1'b0, 1'b0, '0),
            req_row(REQ_ADD_EXT, 1'b1, LVL_SLOW, DEV_DB, 64'd300, 1'b0, 1'b0, '0),
            req_row(REQ_SUB_EXT, 1'b1, LVL_SLOW, DEV_DB, 64'd1, 1'b0, 1'b0, '0),
            req_row(REQ_ADD_EXT, 1'b1, LVL_DB, DEV_DB, 64'd750, 1'b0, 1'b0, '0),
            req_row(REQ_ADD_EXT, 1'b1, LVL_LOG, DEV_WAL, 64'd10, 1'b0, 1'b0, '0),
            req_row(REQ_SELECT, 1'b0, LVL_SLOW, DEV_WAL, 64'd0, 1'b0, 1'b0, '0),
            req_row(REQ_SELECT, 1'b1, LVL_SLOW, DEV_SLOW, B_MAX, 1'b1, 1'b0, '0)
        };

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                drive_requests();
                settle();
                write_reg(dir_tbl[i].cfg, dir_tbl[i].item.amt);
            end else begin
                req_backlog.push_back(dir_tbl[i].item);
            end
        end
        drive_requests();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    for (int k = 0; k < 3; k++) cfg_val[k] = t_bytes'($urandom_range(0, 4096));
                    cfg_val[3] = t_bytes'($urandom_range(1, 2048));
                end
                1: begin
                    for (int k = 0; k < 3; k++) cfg_val[k] = '0;
                    cfg_val[3] = B_MAX;
                end
                2: begin
                    for (int k = 0; k < 3; k++) cfg_val[k] = B_MAX;
                    cfg_val[3] = wide_rand();
                end
                3: begin
                    for (int k = 0; k < 4; k++) cfg_val[k] = wide_rand();
                end
                default: begin
                    for (int k = 0; k < 3; k++) cfg_val[k] = t_bytes'($urandom_range(0, 4096));
                    cfg_val[3] = '0;
                end
            endcase
            for (int k = 0; k < 4; k++) write_reg(t_cfg_index'(k), cfg_val[k]);
            calm = (ph == CALM_PHASE);
            repeat (PHASE_REQS) req_backlog.push_back(random_req());
            drive_requests();
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0 && placement_expect_q.size() == 0) begin
            $display("tiered_volume_usage_placement_top: match");
        end else begin
            $display("tiered_volume_usage_placement_top: mismatch");
        end
        $finish;
    end

endmodule
